>>> rtl/jsu_pkg.sv
// Package for the JSON string unescaper: state and result types, codes and
// the hex digit decoder. Used by every module of the block.
`default_nettype none

package jsu_pkg;

  // Decoder modes.
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_ESCAPE  = 2'd1;
  localparam logic [1:0] MODE_HEX     = 2'd2;
  localparam logic [1:0] MODE_DISCARD = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_ESCAPE     = 3'd1;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd2;
  localparam logic [2:0] ERR_HEX        = 3'd3;
  localparam logic [2:0] ERR_RANGE      = 3'd4;

  // Characters of interest.
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Control codes produced by the short escapes.
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0c;
  localparam logic [7:0] CTL_LF = 8'h0a;
  localparam logic [7:0] CTL_CR = 8'h0d;
  localparam logic [7:0] CTL_HT = 8'h09;

  // Decoder state. Only the low 12 bits of the code point are kept while
  // digits arrive; the final digit is appended at the check.
  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  seen;
    logic [11:0] accum;
    logic        bad;
  } jsu_state_t;

  localparam jsu_state_t STATE_RESET = '{mode: MODE_NORMAL, seen: 2'd0,
                                         accum: 12'd0, bad: 1'b0};

  // One result beat.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
    logic       last;
  } jsu_result_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/jsu_step.sv
// Combinational decode of one byte: next decoder state and the result beat.
// Depends on jsu_pkg.
`default_nettype none

module jsu_step (
  input  jsu_pkg::jsu_state_t  state,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output jsu_pkg::jsu_state_t  state_nxt,
  output jsu_pkg::jsu_result_t res
);
  import jsu_pkg::*;

  logic [4:0]  hv;
  logic [15:0] cp;

  assign hv = hex_value(in_byte);
  assign cp = {state.accum, hv[3:0]};

  always_comb begin
    state_nxt = state;
    res       = '{valid: 1'b0, data: 8'd0, kind: KIND_BYTE, err: ERR_NONE,
                  last: in_last};

    // Decide the result and the mode changes that hold no result.
    unique case (state.mode)
      MODE_NORMAL: begin
        if (in_byte == CH_BSLASH) begin
          if (in_last) begin
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_ESCAPE;
          end else begin
            state_nxt.mode = MODE_ESCAPE;
          end
        end else begin
          res.valid = 1'b1;
          res.data  = in_byte;
        end
      end
      MODE_ESCAPE: begin
        res.valid = 1'b1;
        unique case (in_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: res.data = in_byte;
          CH_B: res.data = CTL_BS;
          CH_F: res.data = CTL_FF;
          CH_N: res.data = CTL_LF;
          CH_R: res.data = CTL_CR;
          CH_T: res.data = CTL_HT;
          CH_U: begin
            if (in_last) begin
              res.kind = KIND_ERROR;
              res.err  = ERR_INCOMPLETE;
            end else begin
              res.valid       = 1'b0;
              state_nxt.mode  = MODE_HEX;
              state_nxt.seen  = 2'd0;
              state_nxt.accum = 12'd0;
              state_nxt.bad   = 1'b0;
            end
          end
          default: begin
            res.kind = KIND_ERROR;
            res.err  = ERR_ESCAPE;
          end
        endcase
      end
      MODE_HEX: begin
        if (state.seen != 2'd3) begin
          // Collect one more digit; a bad one is reported at the fourth, unless the string ends first.
          state_nxt.bad   = state.bad | ~hv[4];
          state_nxt.accum = cp[11:0];
          state_nxt.seen  = state.seen + 2'd1;
          if (in_last) begin
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_INCOMPLETE;
          end
        end else begin
          res.valid = 1'b1;
          if (state.bad || !hv[4]) begin
            res.kind = KIND_ERROR;
            res.err  = ERR_HEX;
          end else if (cp[15:7] != 9'd0) begin
            res.kind = KIND_ERROR;
            res.err  = ERR_RANGE;
          end else begin
            res.data = cp[7:0];
          end
        end
      end
      MODE_DISCARD: begin
        if (in_last) begin
          res.valid = 1'b1;
          res.kind  = KIND_END;
        end
      end
      default: ;
    endcase

    // Every result picks the following mode; the final byte clears all.
    if (res.valid) begin
      if (in_last) begin
        state_nxt = STATE_RESET;
      end else if (res.kind == KIND_ERROR) begin
        state_nxt.mode = MODE_DISCARD;
      end else begin
        state_nxt.mode = MODE_NORMAL;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/jsu_out_reg.sv
// Output register of the result channel: holds one beat until it is taken.
// Depends on jsu_pkg.
`default_nettype none

module jsu_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  jsu_pkg::jsu_result_t res,
  output logic                 free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,   // out_byte
  output logic [4:0]           out_tuser,   // kind [1:0], error_code [4:2]
  output logic                 out_tlast
);
  import jsu_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;
  logic [1:0] kind_r;
  logic [2:0] err_r;
  logic       last_r;

  // The slot is free when empty or when its beat leaves this cycle.
  assign free = !valid_r || out_tready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= res.data;
      kind_r <= res.kind;
      err_r  <= res.err;
      last_r <= res.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = {err_r, kind_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

>>> rtl/json_string_unescaper_core.sv
// Top level of the JSON string unescaper: input register, decoder state and
// the output register. Depends on jsu_pkg, jsu_step and jsu_out_reg.
//
// Usage:
//   The input channel carries the escaped body of a JSON string, one byte a
//   beat in in_tdata, with in_tlast on the final byte. The result channel
//   carries at most one beat per input byte: out_tdata is the decoded byte,
//   out_tuser holds the kind (byte, error, end marker) and the error code,
//   and out_tlast marks the beat caused by the final input byte. Escape
//   prefixes, the first three digits of a unicode escape and bytes discarded
//   after an error give no beat; the final byte always gives one. The byte
//   waits in the input register after its handshake; its result then enters
//   the output register, which drives out_tvalid, when that slot is free.
//   Throughput is one byte per cycle unless the receiver stalls; the state
//   update is a single level of logic between the input and state registers.
//   When the receiver stalls, the output register holds its beat, the input
//   register holds the next byte, and in_tready drops; bytes that give no
//   result still move on. A synchronous active-low reset empties both
//   registers and returns the decoder to normal mode.
`default_nettype none

module json_string_unescaper_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic [4:0] out_tuser,   // kind [1:0], error_code [4:2]
  output logic       out_tlast
);
  import jsu_pkg::*;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  jsu_state_t  state_r;
  jsu_state_t  state_nxt;
  jsu_result_t res;
  logic        out_free;
  logic        advance;

  // The registered byte moves on when its result has a free slot or it gives no result.
  assign advance   = in_vld_r && (out_free || !res.valid);
  assign in_tready = !in_vld_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  jsu_step u_step (
    .state     (state_r),
    .in_byte   (in_byte_r),
    .in_last   (in_last_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  jsu_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res.valid),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg.
`default_nettype none

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [4:0] out_tuser,
  input logic       out_tlast
);
  import jsu_pkg::*;

  // A stalled result beat stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // A decoded byte carries no error code.
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_BYTE |-> out_tuser[4:2] == ERR_NONE)
    else $error("decoded byte with an error code");

  // An error beat has a real code and no data byte.
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_ERROR |->
      out_tuser[4:2] != ERR_NONE && out_tdata == 8'd0)
    else $error("malformed error beat");

  // An end marker only closes a string and carries nothing else.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_END |->
      out_tlast && out_tdata == 8'd0 && out_tuser[4:2] == ERR_NONE)
    else $error("malformed end marker");

endmodule

bind json_string_unescaper_core jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

>>> dv/json_string_unescaper_core_tb.sv
// Self-checking testbench for json_string_unescaper_core: a directed table, then random
// JSON string bodies, checked beat by beat against a behavioral decoder.
// Depends on jsu_pkg for the result type, codes and character constants.
`timescale 1ns / 1ps

module json_string_unescaper_core_tb;
  import jsu_pkg::*;

  localparam int          RANDOM_ITEMS = 1500;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          MAX_REPORTS  = 40;
  localparam int          PRESSURE_AT  = 600;
  localparam int          HOLD_CYCLES  = 400;

  localparam logic [7:0]  CH_DIGIT0  = 8'h30;
  localparam logic [7:0]  CH_LOWER_A = 8'h61;
  localparam logic [7:0]  CH_UPPER_A = 8'h41;
  localparam logic [15:0] MAX_CODE   = 16'h007f;

  localparam logic [7:0]  SHORT_ESCAPES [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                                CH_F, CH_N, CH_R, CH_T};

  // One input byte, with an expected result typed in where it is obvious.
  typedef struct packed {
    logic [7:0]  b;
    logic        fin;
    logic        typed;
    jsu_result_t res;
  } stim_item_t;

  localparam jsu_result_t NO_BEAT = '0;

  function automatic jsu_result_t beat(logic [7:0] d, logic [1:0] k, logic [2:0] e,
                                       logic l);
    beat = '{valid: 1'b1, data: d, kind: k, err: e, last: l};
  endfunction

  localparam int N_DIRECTED = 32;
  localparam stim_item_t DIRECTED [0:N_DIRECTED-1] = '{
    // Plain byte extremes right after reset.
    '{8'h00, 1'b0, 1'b1, beat(8'h00, KIND_BYTE, ERR_NONE, 1'b0)},
    '{8'hff, 1'b1, 1'b1, beat(8'hff, KIND_BYTE, ERR_NONE, 1'b1)},
    // A short escape, left to the decoder model.
    '{CH_BSLASH, 1'b0, 1'b1, NO_BEAT},
    '{CH_T,      1'b0, 1'b0, NO_BEAT},
    // Unknown escape letter 'q', one discarded byte, then the end marker.
    '{CH_BSLASH, 1'b0, 1'b1, NO_BEAT},
    '{8'h71,     1'b0, 1'b1, beat(8'h00, KIND_ERROR, ERR_ESCAPE, 1'b0)},
    '{8'h5a,     1'b0, 1'b1, NO_BEAT},
    '{8'h41,     1'b1, 1'b1, beat(8'h00, KIND_END, ERR_NONE, 1'b1)},
    // Backslash as the final byte.
    '{CH_BSLASH, 1'b1, 1'b1, beat(8'h00, KIND_ERROR, ERR_ESCAPE, 1'b1)},
    // The string ends right after u.
    '{CH_BSLASH, 1'b0, 1'b1, NO_BEAT},
    '{CH_U,      1'b1, 1'b1, beat(8'h00, KIND_ERROR, ERR_INCOMPLETE, 1'b1)},
    // A bad digit 'G' followed by an early end still reports incomplete.
    '{CH_BSLASH, 1'b0, 1'b1, NO_BEAT},
    '{CH_U,      1'b0, 1'b1, NO_BEAT},
    '{8'h47,     1'b1, 1'b1, beat(8'h00, KIND_ERROR, ERR_INCOMPLETE, 1'b1)},
    // Largest code point that decodes, with a lower-case digit.
    '{CH_BSLASH, 1'b0, 1'b1, NO_BEAT},
    '{CH_U,      1'b0, 1'b1, NO_BEAT},
    '{8'h30,     1'b0, 1'b1, NO_BEAT},
    '{8'h30,     1'b0, 1'b1, NO_BEAT},
    '{8'h37,     1'b0, 1'b1, NO_BEAT},
    '{8'h66,     1'b0, 1'b0, NO_BEAT},
    // Smallest code point out of range, ending the string.
    '{CH_BSLASH, 1'b0, 1'b1, NO_BEAT},
    '{CH_U,      1'b0, 1'b1, NO_BEAT},
    '{8'h30,     1'b0, 1'b1, NO_BEAT},
    '{8'h30,     1'b0, 1'b1, NO_BEAT},
    '{8'h38,     1'b0, 1'b1, NO_BEAT},
    '{8'h30,     1'b1, 1'b1, beat(8'h00, KIND_ERROR, ERR_RANGE, 1'b1)},
    // A bad first digit 'z' wins over a large code point.
    '{CH_BSLASH, 1'b0, 1'b1, NO_BEAT},
    '{CH_U,      1'b0, 1'b1, NO_BEAT},
    '{8'h7a,     1'b0, 1'b1, NO_BEAT},
    '{8'h46,     1'b0, 1'b1, NO_BEAT},
    '{8'h46,     1'b0, 1'b1, NO_BEAT},
    '{8'h46,     1'b1, 1'b1, beat(8'h00, KIND_ERROR, ERR_HEX, 1'b1)}
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;    // out_byte
  logic [4:0] out_tuser;    // kind [1:0], error_code [4:2]
  logic       out_tlast;

  json_string_unescaper_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stim_item_t  byte_stream [$];
  jsu_result_t decoded_q [$];
  int          drv_idx       = 0;
  int          acc_idx       = 0;
  int          fail_count    = 0;
  int          beats_checked = 0;
  int          error_beats   = 0;
  int          end_markers   = 0;
  int          strings_sent  = 0;
  int          cycle_count   = 0;

  // Decoder model state, at its reset values.
  logic [1:0]  dec_mode  = MODE_NORMAL;
  logic [1:0]  dec_seen  = 2'd0;
  logic [15:0] dec_accum = 16'd0;
  logic        dec_bad   = 1'b0;

  // Returns 1 for a hex digit and its value in v, else 0 with v = 0.
  function automatic logic hex_nibble(input logic [7:0] b, output logic [3:0] v);
    v = 4'd0;
    if (b >= CH_DIGIT0 && b < CH_DIGIT0 + 8'd10) begin
      v = 4'(b - CH_DIGIT0);
      return 1'b1;
    end
    if (b >= CH_LOWER_A && b < CH_LOWER_A + 8'd6) begin
      v = 4'(b - CH_LOWER_A + 8'd10);
      return 1'b1;
    end
    if (b >= CH_UPPER_A && b < CH_UPPER_A + 8'd6) begin
      v = 4'(b - CH_UPPER_A + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Builds a result beat and moves the model to the mode that follows it.
  function automatic jsu_result_t emit_beat(logic [7:0] d, logic [1:0] k, logic [2:0] e,
                                            logic fin);
    if (fin) begin
      dec_mode  = MODE_NORMAL;
      dec_seen  = 2'd0;
      dec_accum = 16'd0;
      dec_bad   = 1'b0;
    end else if (k == KIND_ERROR) begin
      dec_mode = MODE_DISCARD;
    end else begin
      dec_mode = MODE_NORMAL;
    end
    return beat(d, k, e, fin);
  endfunction

  // Decodes one input byte; the result has valid low when no beat is due.
  function automatic jsu_result_t unescape_step(input logic [7:0] b, input logic fin);
    logic [3:0]  nib;
    logic        is_hex;
    logic [15:0] cp;
    is_hex = hex_nibble(b, nib);
    case (dec_mode)
      MODE_NORMAL: begin
        if (b != CH_BSLASH) return emit_beat(b, KIND_BYTE, ERR_NONE, fin);
        if (fin) return emit_beat(8'h00, KIND_ERROR, ERR_ESCAPE, 1'b1);
        dec_mode = MODE_ESCAPE;
        return NO_BEAT;
      end
      MODE_ESCAPE: begin
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: return emit_beat(b, KIND_BYTE, ERR_NONE, fin);
          CH_B: return emit_beat(CTL_BS, KIND_BYTE, ERR_NONE, fin);
          CH_F: return emit_beat(CTL_FF, KIND_BYTE, ERR_NONE, fin);
          CH_N: return emit_beat(CTL_LF, KIND_BYTE, ERR_NONE, fin);
          CH_R: return emit_beat(CTL_CR, KIND_BYTE, ERR_NONE, fin);
          CH_T: return emit_beat(CTL_HT, KIND_BYTE, ERR_NONE, fin);
          CH_U: begin
            if (fin) return emit_beat(8'h00, KIND_ERROR, ERR_INCOMPLETE, 1'b1);
            dec_mode  = MODE_HEX;
            dec_seen  = 2'd0;
            dec_accum = 16'd0;
            dec_bad   = 1'b0;
            return NO_BEAT;
          end
          default: return emit_beat(8'h00, KIND_ERROR, ERR_ESCAPE, fin);
        endcase
      end
      MODE_HEX: begin
        // The first three digits accumulate, or end the string as incomplete; the fourth decides.
        if (dec_seen < 2'd3) begin
          if (!is_hex) dec_bad = 1'b1;
          dec_accum = {dec_accum[11:0], nib};
          dec_seen  = dec_seen + 2'd1;
          if (fin) return emit_beat(8'h00, KIND_ERROR, ERR_INCOMPLETE, 1'b1);
          return NO_BEAT;
        end
        if (dec_bad || !is_hex) return emit_beat(8'h00, KIND_ERROR, ERR_HEX, fin);
        cp = {dec_accum[11:0], nib};
        if (cp > MAX_CODE) return emit_beat(8'h00, KIND_ERROR, ERR_RANGE, fin);
        return emit_beat(cp[7:0], KIND_BYTE, ERR_NONE, fin);
      end
      default: begin
        if (fin) return emit_beat(8'h00, KIND_END, ERR_NONE, 1'b1);
        return NO_BEAT;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("MISMATCH at result beat %0d: %s got 0x%0h, expected 0x%0h",
               beats_checked, what, got, want);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) return CH_DIGIT0 + 8'(nib);
    return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(nib) - 8'd10;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_stream.insert(byte_stream.size(),
                       '{b: b, fin: 1'b0, typed: 1'b0, res: NO_BEAT});
  endtask

  // Appends \u and four digits of cp, with one digit spoiled when bad_pos < 4.
  task automatic push_unicode(input logic [15:0] cp, input int bad_pos);
    logic [7:0] b;
    logic [3:0] scratch;
    push_byte(CH_BSLASH);
    push_byte(CH_U);
    for (int i = 3; i >= 0; i--) begin
      b = hex_char(cp[4*i +: 4], 1'($urandom_range(0, 1)));
      if (3 - i == bad_pos) begin
        do b = 8'($urandom_range(0, 255)); while (hex_nibble(b, scratch));
      end
      push_byte(b);
    end
  endtask

  // One random string body: mostly well-formed segments, some errors and noise.
  task automatic push_string();
    int n_seg;
    int pick;
    n_seg = $urandom_range(1, 8);
    for (int s = 0; s < n_seg; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 60) begin
        push_byte(CH_BSLASH);
        push_byte(SHORT_ESCAPES[$urandom_range(0, 7)]);
      end else if (pick < 75) begin
        push_unicode(16'($urandom_range(0, 127)), 4);
      end else if (pick < 82) begin
        push_unicode(16'($urandom_range(128, 65535)), 4);
      end else if (pick < 88) begin
        push_unicode(16'($urandom_range(0, 65535)), $urandom_range(0, 3));
      end else if (pick < 94) begin
        push_byte(CH_BSLASH);
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        // Cut the string off inside an escape.
        push_byte(CH_BSLASH);
        if ($urandom_range(0, 3) != 0) begin
          push_byte(CH_U);
          repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
        end
        break;
      end
    end
    byte_stream[byte_stream.size() - 1].fin = 1'b1;
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (drv_idx < byte_stream.size()) begin
        in_tvalid <= 1'b1;
        in_tdata  <= byte_stream[drv_idx].b;
        in_tlast  <= byte_stream[drv_idx].fin;
        drv_idx   <= drv_idx + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a rotating stall pattern per window, full-rate windows, and one
  // long hold-off that backs the block up into its input.
  logic [15:0] stall_pat = 16'hffff;
  int          win_left  = 0;
  logic        full_rate = 1'b1;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (!hold_done && acc_idx >= PRESSURE_AT) begin
        out_tready <= 1'b0;
        hold_left  <= HOLD_CYCLES;
        hold_done  <= 1'b1;
      end else begin
        out_tready <= full_rate || stall_pat[0];
        if (win_left == 0) begin
          win_left  <= $urandom_range(20, 80);
          stall_pat <= 16'($urandom);
          full_rate <= ($urandom_range(0, 3) == 0);
        end else begin
          win_left  <= win_left - 1;
          stall_pat <= {stall_pat[0], stall_pat[15:1]};
        end
      end
    end
  end

  // Predict on every accepted input beat, check every accepted result beat.
  always @(posedge clk) begin : monitor
    stim_item_t  item;
    jsu_result_t pred;
    jsu_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        item    = byte_stream[acc_idx];
        acc_idx <= acc_idx + 1;
        pred    = unescape_step(item.b, item.fin);
        if (item.typed) pred = item.res;
        if (pred.valid) decoded_q.insert(decoded_q.size(), pred);
      end
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result beat with nothing expected",
                          16'({out_tuser, out_tdata}), 16'd0);
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.data)
            report_mismatch("out_byte", 16'(out_tdata), 16'(want.data));
          if (out_tuser[1:0] !== want.kind)
            report_mismatch("kind", 16'(out_tuser[1:0]), 16'(want.kind));
          if (out_tuser[4:2] !== want.err)
            report_mismatch("error_code", 16'(out_tuser[4:2]), 16'(want.err));
          if (out_tlast !== want.last)
            report_mismatch("string_done", 16'(out_tlast), 16'(want.last));
          if (want.kind == KIND_ERROR) error_beats++;
          if (want.kind == KIND_END) end_markers++;
        end
        beats_checked++;
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus build, reset, and end of run.
  initial begin
    foreach (DIRECTED[i]) byte_stream.insert(byte_stream.size(), DIRECTED[i]);
    while (byte_stream.size() < N_DIRECTED + RANDOM_ITEMS) push_string();
    foreach (byte_stream[i]) if (byte_stream[i].fin) strings_sent++;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (acc_idx < byte_stream.size()) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch("expected beats left over", 16'(decoded_q.size()), 16'd0);

    $display("Fed %0d string bodies (%0d bytes) with plain, escaped and unicode content.",
             strings_sent, byte_stream.size());
    $display("Checked %0d result beats: %0d errors, %0d end markers, %0d mismatches.",
             beats_checked, error_beats, end_markers, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/jsu_pkg.sv
rtl/jsu_step.sv
rtl/jsu_out_reg.sv
rtl/json_string_unescaper_core.sv
rtl/jsu_checker.sv
dv/json_string_unescaper_core_tb.sv
